// ===== design/xmg_pkg.sv =====
// Package for the xorshift mutation generator: codes, register indexes,
// reset values, control/status structs and the xorshift128 step function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xmg_pkg;

  localparam int INSTRUCTION_COUNT = 64;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_REPLY     = 2'd1;
  localparam logic [1:0] CMD_RANDOMIZE = 2'd2;
  localparam logic [1:0] CMD_RESEED    = 2'd3;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_MUTATE = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_MEMORY_SIZE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_CAPACITY = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_LOW         = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_HIGH        = 2'd3;

  localparam logic [31:0] MEMORY_SIZE_RESET      = 32'd1048576;
  localparam logic [31:0] PROCESS_CAPACITY_RESET = 32'd1024;
  localparam logic [63:0] SEED_LOW_RESET         = 64'd1;
  localparam logic [63:0] SEED_HIGH_RESET        = 64'd0;

  typedef logic [3:0][31:0] gen_t;

  typedef struct packed {
    logic       capture;
    logic       draw_addr;
    logic       draw_proc;
    logic       take_pid;
    logic       emit;
    logic [1:0] kind;
    logic       use_target;
    logic       last;
    logic       reseed;
  } cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       slot_free;
    logic       addr_ok;
    logic       pid_ok;
    logic       div_done;
    logic       out_free;
  } stat_t;

  function automatic gen_t xmg_step(input gen_t g);
    logic [31:0] t;
    logic [31:0] s;
    gen_t        n;
    t = g[3];
    s = g[0];
    t = t ^ (t << 11);
    t = t ^ (t >> 8);
    t = t ^ s ^ (s >> 19);
    n[3] = g[2];
    n[2] = g[1];
    n[1] = s;
    n[0] = t;
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== design/xmg_if.sv =====
// Channel interfaces for the xorshift mutation generator: command input
// and result output, each with valid/ready and payload. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface xmg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] target_address;
  logic [31:0] live_count;
  logic        slot_is_free;

  modport source (output valid, command, target_address, live_count, slot_is_free,
                  input ready);
  modport sink (input valid, command, target_address, live_count, slot_is_free,
                output ready);
  modport monitor (input valid, ready, command, target_address, live_count,
                   slot_is_free);
endinterface

interface xmg_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] write_address;
  logic [7:0]  instruction;
  logic [31:0] process_id;
  logic [31:0] mutation_word;
  logic        last;

  modport source (output valid, kind, write_address, instruction, process_id,
                  mutation_word, last, input ready);
  modport sink (input valid, kind, write_address, instruction, process_id,
                mutation_word, last, output ready);
  modport monitor (input valid, ready, kind, write_address, instruction, process_id,
                   mutation_word, last);
endinterface

`default_nettype wire

// ===== design/xmg_divider.sv =====
// Serial restoring 32-bit divider, one quotient bit per cycle.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
`default_nettype none

module xmg_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] div_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  assign trial = {rem_r, quo_r[31]} - {1'b0, div_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = 6'd32;
    end else if (cnt_r != '0) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 6'd1;
      done_nxt = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) div_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== design/xmg_datapath.sv =====
// Datapath: config registers, xorshift128 state, latched command payload,
// candidate address/process, divider and the output register.
// Depends on xmg_pkg and xmg_divider.
`timescale 1ns / 1ps
`default_nettype none

module xmg_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  xmg_pkg::cmd_t                    cmd,
  output xmg_pkg::stat_t                   stat,
  input  logic                             cfg_we,
  input  logic [xmg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [xmg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [1:0]                       in_command,
  input  logic [31:0]                      in_target_address,
  input  logic [31:0]                      in_live_count,
  input  logic                             in_slot_is_free,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_kind,
  output logic [31:0]                      out_write_address,
  output logic [7:0]                       out_instruction,
  output logic [31:0]                      out_process_id,
  output logic [31:0]                      out_mutation_word,
  output logic                             out_last
);
  import xmg_pkg::*;

  logic [31:0] addr_limit_r, cap_r;
  logic [63:0] seed_low_r, seed_high_r;
  gen_t        gen_r, gen_nxt, gen_step;
  logic [31:0] draw_word;
  logic        draw_en;

  logic [1:0]  cmd_code_r;
  logic [31:0] target_r, live_r, addr_r;
  logic        free_r;
  logic [31:0] pid_r, pid_nxt;

  logic        div_done;
  logic [31:0] div_quo;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r;
  logic [31:0] waddr_r, pid_out_r, word_r;
  logic [7:0]  inst_r;
  logic        last_r;

  assign gen_step  = xmg_step(gen_r);
  assign draw_word = gen_step[0];
  assign draw_en   = cmd.draw_addr | cmd.draw_proc | (cmd.emit & (cmd.kind != KIND_QUERY));

  always_comb begin
    gen_nxt = gen_r;
    if (cmd.reseed) gen_nxt = {seed_high_r, seed_low_r};
    else if (draw_en) gen_nxt = gen_step;
  end

  assign pid_nxt = (live_r == '0) ? '1 : div_quo;

  xmg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.draw_proc),
    .dividend (draw_word),
    .divisor  (live_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_limit_r <= MEMORY_SIZE_RESET;
      cap_r        <= PROCESS_CAPACITY_RESET;
      seed_low_r   <= SEED_LOW_RESET;
      seed_high_r  <= SEED_HIGH_RESET;
      gen_r        <= {SEED_HIGH_RESET, SEED_LOW_RESET};
      pid_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MEMORY_SIZE:      addr_limit_r <= cfg_data[31:0];
          REG_PROCESS_CAPACITY: cap_r        <= cfg_data[31:0];
          REG_SEED_LOW:         seed_low_r   <= cfg_data;
          REG_SEED_HIGH:        seed_high_r  <= cfg_data;
        endcase
      end
      gen_r <= gen_nxt;
      if (cmd.take_pid) pid_r <= pid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_code_r <= in_command;
      target_r   <= in_target_address;
      live_r     <= in_live_count;
      free_r     <= in_slot_is_free;
    end
    if (cmd.draw_addr) addr_r <= draw_word;
  end

  // output register
  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r <= cmd.kind;
      last_r <= cmd.last;
      unique case (cmd.kind)
        KIND_WRITE: begin
          waddr_r   <= cmd.use_target ? target_r : addr_r;
          inst_r    <= 8'(draw_word % INSTRUCTION_COUNT);
          pid_out_r <= '0;
          word_r    <= '0;
        end
        KIND_QUERY: begin
          waddr_r   <= '0;
          inst_r    <= '0;
          pid_out_r <= pid_r;
          word_r    <= '0;
        end
        KIND_MUTATE: begin
          waddr_r   <= '0;
          inst_r    <= '0;
          pid_out_r <= pid_r;
          word_r    <= draw_word;
        end
        default: begin
          waddr_r   <= '0;
          inst_r    <= '0;
          pid_out_r <= '0;
          word_r    <= '0;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_write_address = waddr_r;
  assign out_instruction   = inst_r;
  assign out_process_id    = pid_out_r;
  assign out_mutation_word = word_r;
  assign out_last          = last_r;

  assign stat.command   = cmd_code_r;
  assign stat.slot_free = free_r;
  assign stat.addr_ok   = (addr_r < addr_limit_r);
  assign stat.pid_ok    = (pid_r < cap_r);
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// ===== design/xmg_ctrl.sv =====
// Controller FSM: sequences draws, the divide and result transfers per
// command, and holds the query-pending flag. Depends on xmg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xmg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  xmg_pkg::stat_t stat,
  output xmg_pkg::cmd_t  cmd
);
  import xmg_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_DRAW_A = 4'd2;
  localparam logic [3:0] S_DRAW_P = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_POST   = 4'd5;
  localparam logic [3:0] S_EMIT_W = 4'd6;
  localparam logic [3:0] S_EMIT_Q = 4'd7;
  localparam logic [3:0] S_EMIT_M = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       awaiting_r, awaiting_nxt;
  logic       is_rand;

  assign is_rand  = (stat.command == CMD_RANDOMIZE);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    awaiting_nxt = awaiting_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.command)
          CMD_TICK: begin
            awaiting_nxt = 1'b0;
            state_nxt    = S_DRAW_A;
          end
          CMD_REPLY: begin
            awaiting_nxt = 1'b0;
            state_nxt    = (awaiting_r && !stat.slot_free) ? S_EMIT_M : S_IDLE;
          end
          CMD_RANDOMIZE: state_nxt = S_EMIT_W;
          CMD_RESEED: begin
            cmd.reseed   = 1'b1;
            awaiting_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end
        endcase
      end
      S_DRAW_A: begin
        cmd.draw_addr = 1'b1;
        state_nxt     = S_DRAW_P;
      end
      S_DRAW_P: begin
        cmd.draw_proc = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.take_pid = 1'b1;
          state_nxt    = S_POST;
        end
      end
      S_POST: begin
        priority if (stat.addr_ok) state_nxt = S_EMIT_W;
        else if (stat.pid_ok)      state_nxt = S_EMIT_Q;
        else                       state_nxt = S_IDLE;
      end
      S_EMIT_W: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.kind       = KIND_WRITE;
          cmd.use_target = is_rand;
          cmd.last       = is_rand || !stat.pid_ok;
          state_nxt      = (!is_rand && stat.pid_ok) ? S_EMIT_Q : S_IDLE;
        end
      end
      S_EMIT_Q: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.kind     = KIND_QUERY;
          cmd.last     = 1'b1;
          awaiting_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EMIT_M: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_MUTATE;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      awaiting_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      awaiting_r <= awaiting_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/xorshift_mutation_generator.sv =====
// Top level of the xorshift mutation generator: controller plus datapath.
// Depends on xmg_pkg, xmg_if, xmg_ctrl, xmg_datapath.
//
//   port    role    carries
//   in_ch   sink    command, target_address, live_count, slot_is_free
//   out_ch  source  kind, write_address, instruction, process_id,
//                   mutation_word, last
//   cfg_*   write   memory_size, process_capacity, seed_low, seed_high
//
// One item at a time. A tick draws an address and a process, then runs the
// serial divider, then makes up to two result transfers.
// Results sit in one output register; a held result only stalls the next emit.
// Reset is synchronous, active low; config and generator words take reset values.
`timescale 1ns / 1ps
`default_nettype none

module xorshift_mutation_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  xmg_in_if.sink                          in_ch,
  xmg_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [xmg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [xmg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import xmg_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign in_ch.ready = in_ready;

  xmg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  xmg_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_command        (in_ch.command),
    .in_target_address (in_ch.target_address),
    .in_live_count     (in_ch.live_count),
    .in_slot_is_free   (in_ch.slot_is_free),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_kind          (out_ch.kind),
    .out_write_address (out_ch.write_address),
    .out_instruction   (out_ch.instruction),
    .out_process_id    (out_ch.process_id),
    .out_mutation_word (out_ch.mutation_word),
    .out_last          (out_ch.last)
  );

endmodule

`default_nettype wire

// ===== design/xmg_checker.sv =====
// Port-level checks for the xorshift mutation generator, bound to the top.
// Depends on xmg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xmg_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [31:0] out_write_address,
  input  logic [7:0]  out_instruction,
  input  logic [31:0] out_process_id,
  input  logic [31:0] out_mutation_word,
  input  logic        out_last
);
  import xmg_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_kind) && $stable(out_last) &&
      $stable(out_process_id) && $stable(out_write_address))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous command in progress");

  a_query_mutate_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_QUERY || out_kind == KIND_MUTATE)
      |-> out_last && out_write_address == '0 && out_instruction == '0)
    else $error("query or mutate result malformed");

  a_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_WRITE
      |-> out_process_id == '0 && out_mutation_word == '0)
    else $error("write result carries process fields");

endmodule

bind xorshift_mutation_generator xmg_checker u_xmg_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_kind          (out_ch.kind),
  .out_write_address (out_ch.write_address),
  .out_instruction   (out_ch.instruction),
  .out_process_id    (out_ch.process_id),
  .out_mutation_word (out_ch.mutation_word),
  .out_last          (out_ch.last)
);

`default_nettype wire
